// ===== hw/rtl/ffpa_pkg.sv =====
// Package for the first-fit page allocator: operation codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package ffpa_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MAX   = 2'd2,
        OP_SCOPE = 2'd3
    } op_t;

    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_PAGES = 2'd1;
    localparam logic [1:0] CFG_SHIFT = 2'd2;

    // Commands from controller to datapath.
    typedef struct packed {
        logic latch;      // capture the transaction and reset the walk
        logic rd;         // issue a table read at the walk index
        logic step;       // consume read data (scan one entry)
        logic shift_up;   // move entry idx-1 to idx (insert), idx decrements
        logic shift_dn;   // move entry idx+1 to idx (remove), idx increments
        logic put;        // write the new run at pos
        logic finish;     // drive the result strobe
    } ffpa_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic scan_done;  // walk index reached run_count
        logic hit;        // entry just scanned matches the search
        logic refuse;     // allocate refused before the walk
        logic tail_ok;    // tail space holds the run
        logic at_pos;     // shift index reached the target position
        logic last;       // shift index reached the end for removal
    } ffpa_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ffpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ffpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ffpa_ctrl.sv =====
// Controller state machine for the first-fit page allocator.
// Depends on ffpa_pkg.
`default_nettype none
module ffpa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        operation,
    input  wire ffpa_pkg::ffpa_sts_t sts,
    output logic                   busy,
    output ffpa_pkg::ffpa_cmd_t    cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_SCAN, S_DECIDE, S_SHIFT_UP, S_SHIFT_DN, S_PUT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_next;
    logic [1:0] op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    op_next    = operation;
                    state_next = (ffpa_pkg::op_t'(operation) == ffpa_pkg::OP_SCOPE)
                                 ? S_DONE : S_READ;
                end
            end
            S_READ:
            begin
                if (sts.scan_done || (op_reg == ffpa_pkg::OP_ALLOC && sts.refuse))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                state_next = (sts.hit && op_reg != ffpa_pkg::OP_MAX) ? S_DECIDE : S_READ;
            end
            S_DECIDE:
            begin
                // hit is held by the datapath once found
                if (op_reg == ffpa_pkg::OP_ALLOC)
                begin
                    state_next = (!sts.refuse && (sts.hit || sts.tail_ok)) ? S_SHIFT_UP
                                 : S_DONE;
                end
                else if (op_reg == ffpa_pkg::OP_FREE)
                begin
                    state_next = sts.hit ? S_SHIFT_DN : S_DONE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT_UP:
            begin
                if (sts.at_pos)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.shift_up = 1'b1;
                end
            end
            S_SHIFT_DN:
            begin
                if (sts.last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.shift_dn = 1'b1;
                end
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= 2'd0;
            busy      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            busy      <= busy_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ffpa_dp.sv =====
// Datapath for the first-fit page allocator: run table RAMs, walk index,
// gap tracking and result registers. Depends on ffpa_pkg and ffpa_ram.
`default_nettype none
module ffpa_dp #(
    parameter int MAX_RUNS        = 64,
    parameter int PAGE_INDEX_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ffpa_pkg::ffpa_cmd_t cmd,
    output ffpa_pkg::ffpa_sts_t      sts,
    input  wire logic [1:0]          operation,
    input  wire logic [31:0]         size_bytes,
    input  wire logic [31:0]         address,
    input  wire logic [31:0]         base_address,
    input  wire logic [15:0]         total_pages,
    input  wire logic [4:0]          page_shift,
    output logic                     done,
    output logic                     ok,
    output logic [31:0]              block_address,
    output logic [31:0]              largest_free,
    output logic                     in_scope
);
    localparam int IW = $clog2(MAX_RUNS);
    localparam int CW = $clog2(MAX_RUNS + 1);
    localparam int PW = PAGE_INDEX_BITS;
    localparam logic [PW-1:0] PAGE_LIMIT = {PW{1'b1}};

    logic [1:0]    op_reg;
    logic [31:0]   addr_reg;
    logic [PW:0]   need_reg;       // one extra bit flags an oversize request
    logic          zero_reg;
    logic [PW:0]   limit_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] pos_reg;
    logic [PW:0]   cur_reg;        // end page of the previous run
    logic [PW:0]   best_reg;
    logic          hit_reg;
    logic [PW-1:0] used_reg;
    logic [PW-1:0] rd_start, rd_cnt;
    logic [PW-1:0] rd_cnt_freed;   // page count of the run being freed

    // Wide rounding of the request to pages.
    logic [52:0] sz_round;
    logic [52:0] need_wide;
    always_comb
    begin
        sz_round  = {21'd0, size_bytes} + ((53'd1 << page_shift) - 53'd1);
        need_wide = sz_round >> page_shift;
    end

    // Table RAMs.
    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [PW-1:0] wstart, wcnt;
    logic [CW-1:0] idx_m1, idx_p1;

    assign idx_m1 = idx_reg - CW'(1);
    assign idx_p1 = idx_reg + CW'(1);

    always_comb
    begin
        we     = 1'b0;
        waddr  = idx_reg[IW-1:0];
        raddr  = idx_reg[IW-1:0];
        wstart = rd_start;
        wcnt   = rd_cnt;
        if (cmd.shift_up)
        begin
            raddr = idx_m1[IW-1:0];
        end
        else if (cmd.shift_dn)
        begin
            raddr = idx_p1[IW-1:0];
        end
        if (cmd.put)
        begin
            we     = 1'b1;
            waddr  = pos_reg[IW-1:0];
            wstart = cur_reg[PW-1:0];
            wcnt   = need_reg[PW-1:0];
        end
    end

    // Shifts move each entry by a read, then a write (tracked by a phase bit).
    logic          ph_reg;
    logic          mv_we;
    logic [IW-1:0] mv_addr;
    assign mv_we = ph_reg;

    ffpa_ram #(.WIDTH(PW), .DEPTH(MAX_RUNS)) u_start (
        .clk(clk), .we(we || mv_we), .waddr(mv_we ? mv_addr : waddr),
        .wdata(mv_we ? rd_start : wstart), .raddr(raddr), .rdata(rd_start)
    );
    ffpa_ram #(.WIDTH(PW), .DEPTH(MAX_RUNS)) u_cnt (
        .clk(clk), .we(we || mv_we), .waddr(mv_we ? mv_addr : waddr),
        .wdata(mv_we ? rd_cnt : wcnt), .raddr(raddr), .rdata(rd_cnt)
    );

    // Run address of the entry just read.
    logic [31:0] run_addr;
    logic [PW:0] s_ext, gap;
    logic        entry_hit;
    assign run_addr = base_address + ({{(32-PW){1'b0}}, rd_start} << page_shift);
    assign s_ext    = {1'b0, rd_start};
    assign gap      = s_ext - cur_reg;

    always_comb
    begin
        case (ffpa_pkg::op_t'(op_reg))
            ffpa_pkg::OP_ALLOC: entry_hit = (s_ext >= cur_reg) && (gap >= need_reg);
            ffpa_pkg::OP_FREE:  entry_hit = (run_addr == addr_reg);
            default:            entry_hit = 1'b0;
        endcase
    end

    logic [PW:0] tail;
    assign tail = (limit_reg > cur_reg) ? limit_reg - cur_reg : '0;

    assign sts.scan_done = (idx_reg == count_reg);
    assign sts.hit       = cmd.step ? entry_hit : hit_reg;
    assign sts.refuse    = zero_reg || (count_reg == CW'(MAX_RUNS)) || (need_reg > limit_reg);
    assign sts.tail_ok   = tail >= need_reg;
    assign sts.at_pos    = (idx_reg == pos_reg) && !ph_reg;
    assign sts.last      = (idx_p1 >= count_reg) && !ph_reg;

    // Scope bound without truncation.
    logic [52:0] top;
    assign top = {21'd0, base_address} + ({37'd0, total_pages} << page_shift);

    logic [52:0] best_bytes;
    assign best_bytes = {{(52-PW){1'b0}}, best_reg} << page_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            used_reg  <= '0;
            done      <= 1'b0;
            ph_reg    <= 1'b0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            done <= cmd.finish;
            if (cmd.latch)
            begin
                op_reg    <= operation;
                addr_reg  <= address;
                zero_reg  <= (size_bytes == 32'd0);
                need_reg  <= (need_wide > 53'(PAGE_LIMIT)) ? {1'b1, PW'(0)}
                                                          : need_wide[PW:0];
                limit_reg <= (total_pages > 16'(PAGE_LIMIT)) ? {1'b0, PAGE_LIMIT}
                                                             : (PW+1)'(total_pages);
                idx_reg   <= '0;
                cur_reg   <= '0;
                best_reg  <= '0;
                hit_reg   <= 1'b0;
                ok        <= 1'b0;
                block_address <= '0;
                largest_free  <= '0;
                in_scope  <= (ffpa_pkg::op_t'(operation) == ffpa_pkg::OP_SCOPE) &&
                             ({21'd0, address} >= {21'd0, base_address}) &&
                             ({21'd0, address} < top);
            end
            if (cmd.step)
            begin
                if (entry_hit)
                begin
                    hit_reg <= 1'b1;
                    pos_reg <= idx_reg;
                end
                else
                begin
                    if (s_ext > cur_reg && gap > best_reg)
                    begin
                        best_reg <= gap;
                    end
                    cur_reg <= s_ext + {1'b0, rd_cnt};
                    idx_reg <= idx_p1;
                end
            end
            // Decide: settle the insert position and the walk start for a shift.
            if (cmd.rd == 1'b0 && !cmd.step && !cmd.latch && !ph_reg &&
                !cmd.shift_up && !cmd.shift_dn && !cmd.put && !cmd.finish)
            begin
                if (!hit_reg)
                begin
                    pos_reg <= count_reg;
                    if (ffpa_pkg::op_t'(op_reg) == ffpa_pkg::OP_MAX && tail > best_reg)
                    begin
                        best_reg <= tail;
                    end
                end
                if (ffpa_pkg::op_t'(op_reg) == ffpa_pkg::OP_ALLOC)
                begin
                    idx_reg <= count_reg;
                end
            end
            // Move one entry: read at idx-1 (or idx+1), write at idx next cycle.
            ph_reg <= (cmd.shift_up || cmd.shift_dn) && !ph_reg;
            if (cmd.shift_up || cmd.shift_dn)
            begin
                mv_addr <= idx_reg[IW-1:0];
            end
            if (ph_reg)
            begin
                idx_reg <= (op_reg == ffpa_pkg::OP_ALLOC) ? idx_m1 : idx_p1;
            end
            if (cmd.put)
            begin
                ok            <= 1'b1;
                block_address <= base_address +
                                 ({{(32-PW){1'b0}}, cur_reg[PW-1:0]} << page_shift);
                count_reg     <= count_reg + CW'(1);
                used_reg      <= used_reg + need_reg[PW-1:0];
            end
            if (cmd.finish)
            begin
                if (ffpa_pkg::op_t'(op_reg) == ffpa_pkg::OP_FREE && hit_reg)
                begin
                    ok        <= 1'b1;
                    count_reg <= count_reg - CW'(1);
                    used_reg  <= used_reg - rd_cnt_freed;
                end
                if (ffpa_pkg::op_t'(op_reg) == ffpa_pkg::OP_MAX)
                begin
                    largest_free <= (best_bytes > 53'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                 : best_bytes[31:0];
                end
            end
        end
    end

    // Capture the page count of the run being freed on the hit.
    always_ff @(posedge clk)
    begin
        if (cmd.step && entry_hit)
        begin
            rd_cnt_freed <= rd_cnt;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_page_block_allocator.sv =====
// First-fit page allocator, top level: config registers, controller, datapath.
// Depends on ffpa_pkg, ffpa_ctrl, ffpa_dp (and ffpa_ram through the datapath).
// Scope checks answer without a walk and an allocate refused up front skips it; free,
// max-size and other allocates walk the run table, and a granted allocate or free then
// shifts any later entries, each moved by a read and then a write through the
// single-read-port run table. One transaction at a time: busy drops in the cycle the
// result strobe is high. Reset clears the run count and the base and page-count registers
// and sets the page shift to 12; the receiver cannot stall.
`default_nettype none
module first_fit_page_block_allocator #(
    parameter int MAX_RUNS        = 64,
    parameter int PAGE_INDEX_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] size_bytes,
    input  wire logic [31:0] address,
    output logic             done,
    output logic             ok,
    output logic [31:0]      block_address,
    output logic [31:0]      largest_free,
    output logic             in_scope,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    logic [31:0] base_address_reg;
    logic [15:0] total_pages_reg;
    logic [4:0]  page_shift_reg;

    ffpa_pkg::ffpa_cmd_t cmd;
    ffpa_pkg::ffpa_sts_t sts;

    // Hold configuration; the user must write only between transactions (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
            total_pages_reg  <= '0;
            page_shift_reg   <= 5'd12;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ffpa_pkg::CFG_BASE:  base_address_reg <= cfg_data;
                ffpa_pkg::CFG_PAGES: total_pages_reg  <= cfg_data[15:0];
                ffpa_pkg::CFG_SHIFT: page_shift_reg   <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Controller sequences the walk, shift and result strobe.
    ffpa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start && !busy), .operation(operation),
        .sts(sts), .busy(busy), .cmd(cmd)
    );

    // Datapath holds the run table and computes every result.
    ffpa_dp #(.MAX_RUNS(MAX_RUNS), .PAGE_INDEX_BITS(PAGE_INDEX_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .operation(operation), .size_bytes(size_bytes), .address(address),
        .base_address(base_address_reg), .total_pages(total_pages_reg),
        .page_shift(page_shift_reg), .done(done), .ok(ok),
        .block_address(block_address), .largest_free(largest_free),
        .in_scope(in_scope)
    );
endmodule
`default_nettype wire

// ===== tb/first_fit_page_block_allocator_tb.sv =====
// Self-checking testbench for first_fit_page_block_allocator: directed table plus
// random allocate/free/query traffic checked against an in-bench allocator model.
// Depends on ffpa_pkg and the RTL of the allocator.
`default_nettype none
module first_fit_page_block_allocator_tb;

    localparam int RUN_SLOTS  = 64;
    localparam int PAGE_LIMIT = 65535;

    typedef struct {
        logic        ok;
        logic [31:0] block_address;
        logic [31:0] largest_free;
        logic        in_scope;
    } answer_t;

    typedef struct {
        ffpa_pkg::op_t op;
        logic [31:0]   size;
        logic [31:0]   addr;
        logic          typed;  // expected answer typed in below
        answer_t       want;
    } vector_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [31:0] size_bytes;
    logic [31:0] address;
    logic        done;
    logic        ok;
    logic [31:0] block_address;
    logic [31:0] largest_free;
    logic        in_scope;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    first_fit_page_block_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .size_bytes(size_bytes), .address(address),
        .done(done), .ok(ok), .block_address(block_address),
        .largest_free(largest_free), .in_scope(in_scope),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Allocator shadow state.
    logic [31:0] shadow_base;
    logic [15:0] shadow_pages;
    logic [4:0]  shadow_shift;
    int unsigned run_first[RUN_SLOTS];
    int unsigned run_len[RUN_SLOTS];
    int unsigned runs_held;

    answer_t pending_answers[$];
    int          mismatches;
    int          results_seen;
    int          allocs_granted;
    int          frees_granted;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [31:0] run_byte_address(int unsigned idx);
        logic [63:0] off;
        off = 64'(run_first[idx]) << shadow_shift;
        return 32'(64'(shadow_base) + off);
    endfunction

    // Compute the answer for one transaction and advance the shadow table.
    function automatic answer_t allocator_outcome(ffpa_pkg::op_t op, logic [31:0] size,
                                                  logic [31:0] addr);
        answer_t a;
        longint unsigned limit, need, cur, best, bytes, top;
        int unsigned pos;
        bit found;
        a = '{1'b0, 32'd0, 32'd0, 1'b0};
        limit = (shadow_pages > PAGE_LIMIT) ? PAGE_LIMIT : shadow_pages;
        cur = 0;
        found = 0;
        case (op)
            ffpa_pkg::OP_ALLOC:
            begin
                if (size == 0 || runs_held >= RUN_SLOTS)
                    return a;
                need = (64'(size) + (64'd1 << shadow_shift) - 1) >> shadow_shift;
                if (need > limit)
                    return a;
                pos = runs_held;
                for (int i = 0; i < runs_held; i++)
                begin
                    if (!found && run_first[i] >= cur && run_first[i] - cur >= need)
                    begin
                        pos = i;
                        found = 1;
                    end
                    if (!found)
                        cur = run_first[i] + run_len[i];
                end
                if (!found && ((limit > cur) ? limit - cur : 0) < need)
                    return a;
                for (int i = runs_held; i > pos; i--)
                begin
                    run_first[i] = run_first[i-1];
                    run_len[i] = run_len[i-1];
                end
                run_first[pos] = 32'(cur);
                run_len[pos] = 32'(need);
                runs_held++;
                a.ok = 1'b1;
                a.block_address = run_byte_address(pos);
            end
            ffpa_pkg::OP_FREE:
            begin
                for (int i = 0; i < runs_held; i++)
                begin
                    if (!found && run_byte_address(i) == addr)
                    begin
                        found = 1;
                        for (int j = i; j + 1 < runs_held; j++)
                        begin
                            run_first[j] = run_first[j+1];
                            run_len[j] = run_len[j+1];
                        end
                    end
                end
                if (found)
                begin
                    runs_held--;
                    a.ok = 1'b1;
                end
            end
            ffpa_pkg::OP_MAX:
            begin
                best = 0;
                for (int i = 0; i < runs_held; i++)
                begin
                    if (run_first[i] > cur && run_first[i] - cur > best)
                        best = run_first[i] - cur;
                    cur = run_first[i] + run_len[i];
                end
                if (limit > cur && limit - cur > best)
                    best = limit - cur;
                bytes = best << shadow_shift;
                a.largest_free = (bytes > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(bytes);
            end
            default:
            begin
                top = 64'(shadow_base) + (64'(shadow_pages) << shadow_shift);
                a.in_scope = (addr >= shadow_base) && (64'(addr) < top);
            end
        endcase
        return a;
    endfunction

    // Check each strobed result against the oldest expectation.
    always @(posedge clk)
    begin
        answer_t w;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t", $time);
            end
            else
            begin
                w = pending_answers.pop_front();
                if (ok !== w.ok || block_address !== w.block_address ||
                    largest_free !== w.largest_free || in_scope !== w.in_scope)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0t: exp ok=%0b addr=%h max=%h scope=%0b,",
                                  " got ok=%0b addr=%h max=%h scope=%0b"},
                                 $time, w.ok, w.block_address, w.largest_free,
                                 w.in_scope, ok, block_address, largest_free, in_scope);
                end
            end
        end
    end

    task automatic idle_cycles(int n);
        repeat (n) @(negedge clk);
    endtask

    // Drop start, drain outstanding results, then idle to settle.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        idle_cycles(8);
    endtask

    // Write one register; only called while idle.
    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            ffpa_pkg::CFG_BASE:  shadow_base = value;
            ffpa_pkg::CFG_PAGES: shadow_pages = value[15:0];
            ffpa_pkg::CFG_SHIFT: shadow_shift = value[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_region(logic [31:0] base, logic [15:0] pages, logic [4:0] shift);
        drain_results();
        write_register(ffpa_pkg::CFG_BASE, base);
        write_register(ffpa_pkg::CFG_PAGES, {16'h0, pages});
        write_register(ffpa_pkg::CFG_SHIFT, {27'h0, shift});
    endtask

    // Issue one transaction at a falling edge; hold start until the block takes it.
    // Start stays high afterwards until the next transaction or a drain.
    task automatic issue(ffpa_pkg::op_t op, logic [31:0] size, logic [31:0] addr,
                         int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            idle_cycles(gap);
        end
        start <= 1'b1;
        operation <= op;
        size_bytes <= size;
        address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_answers.push_back(allocator_outcome(op, size, addr));
        if (op == ffpa_pkg::OP_ALLOC)
            allocs_granted += pending_answers[$].ok;
        if (op == ffpa_pkg::OP_FREE)
            frees_granted += pending_answers[$].ok;
    endtask

    function automatic logic [31:0] pick_free_address();
        if (runs_held != 0 && $urandom_range(0, 9) < 8)
            return run_byte_address($urandom_range(0, runs_held - 1));
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_size();
        int unsigned sel;
        logic [31:0] page;
        sel = $urandom_range(0, 19);
        page = 32'd1 << shadow_shift;
        if (sel == 0)
            return 32'd0;
        if (sel == 1)
            return $urandom();
        if (sel < 12)
            return $urandom_range(1, 4 * page);
        return page * $urandom_range(1, 6);
    endfunction

    vector_t directed[] = '{
        '{ffpa_pkg::OP_MAX,   32'd0, 32'd0, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_ALLOC, 32'd1, 32'd0, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_SCOPE, 32'd0, 32'd0, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_FREE,  32'd0, 32'd0, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b0}}
    };

    vector_t region_rows[] = '{
        '{ffpa_pkg::OP_ALLOC, 32'd0,         32'd0,         1'b1,
          '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0,         1'b1,
          '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_ALLOC, 32'd4096,      32'd0,         1'b0,
          '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_ALLOC, 32'd4097,      32'd0,         1'b0,
          '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_ALLOC, 32'd1,         32'd0,         1'b0,
          '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_FREE,  32'd0,         32'h1000_1000, 1'b0,
          '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_ALLOC, 32'd4096,      32'd0,         1'b0,
          '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_FREE,  32'd0,         32'h1234_5678, 1'b1,
          '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_MAX,   32'd0,         32'd0,         1'b0,
          '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_SCOPE, 32'd0,         32'h0FFF_FFFF, 1'b1,
          '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_SCOPE, 32'd0,         32'h1000_0000, 1'b1,
          '{1'b0, 32'd0, 32'd0, 1'b1}},
        '{ffpa_pkg::OP_SCOPE, 32'd0,         32'h1000_FFFF, 1'b1,
          '{1'b0, 32'd0, 32'd0, 1'b1}},
        '{ffpa_pkg::OP_SCOPE, 32'd0,         32'h1001_0000, 1'b1,
          '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ffpa_pkg::OP_SCOPE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
          '{1'b0, 32'd0, 32'd0, 1'b0}}
    };

    task automatic walk_table(vector_t rows[]);
        answer_t got;
        foreach (rows[i])
        begin
            issue(rows[i].op, rows[i].size, rows[i].addr, $urandom_range(0, 3));
            // A typed row overrides the computed expectation so the table is its own check.
            if (rows[i].typed)
                pending_answers[$] = rows[i].want;
        end
    endtask

    initial
    begin
        int items;
        int drained_once;
        ffpa_pkg::op_t op;
        int unsigned r;
        logic [31:0] a;
        rst_n = 1'b0;
        start = 1'b0;
        operation = ffpa_pkg::OP_ALLOC;
        size_bytes = '0;
        address = '0;
        cfg_we = 1'b0;
        cfg_index = ffpa_pkg::CFG_BASE;
        cfg_data = '0;
        shadow_base = '0;
        shadow_pages = '0;
        shadow_shift = 5'd12;
        runs_held = 0;
        mismatches = 0;
        results_seen = 0;
        allocs_granted = 0;
        frees_granted = 0;
        drained_once = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // After reset: empty region, nothing fits.
        walk_table(directed);

        // 16 pages of 4 KiB at 0x1000_0000.
        set_region(32'h1000_0000, 16'd16, 5'd12);
        walk_table(region_rows);

        // Fill the run table to refuse on a full table.
        set_region(32'h0, 16'hFFFF, 5'd0);
        repeat (RUN_SLOTS + 2)
            issue(ffpa_pkg::OP_ALLOC, 32'd1, 32'd0, 0);
        issue(ffpa_pkg::OP_MAX, 32'd0, 32'd0, 0);
        // Wrap and saturation extremes.
        set_region(32'hFFFF_F000, 16'hFFFF, 5'd31);
        issue(ffpa_pkg::OP_MAX, 32'd0, 32'd0, 1);
        issue(ffpa_pkg::OP_SCOPE, 32'd0, 32'hFFFF_FFFF, 1);
        issue(ffpa_pkg::OP_FREE, 32'd0, 32'hFFFF_F000, 1);
        issue(ffpa_pkg::OP_ALLOC, 32'h8000_0000, 32'd0, 1);

        // Random phases over several region settings.
        items = 0;
        while (items < 1350)
        begin
            if (items % 150 == 0)
            begin
                r = $urandom_range(0, 4);
                case (r)
                    0: set_region($urandom(), 16'($urandom_range(1, 64)), 5'd12);
                    1: set_region($urandom(), 16'($urandom_range(1, 300)),
                                  5'($urandom_range(0, 20)));
                    2: set_region($urandom(), 16'hFFFF, 5'($urandom_range(0, 31)));
                    3: set_region($urandom(), 16'($urandom_range(0, 8)),
                                  5'($urandom_range(0, 4)));
                    default: set_region(32'hFFFF_FFFF, 16'($urandom_range(1, 40)), 5'd20);
                endcase
            end
            // Shrink the region under live runs now and then.
            if (items % 450 == 300)
            begin
                drain_results();
                write_register(ffpa_pkg::CFG_PAGES, 32'($urandom_range(0, 10)));
            end
            if (items == 700 && !drained_once)
            begin
                drain_results();
                drained_once = 1;
            end
            r = $urandom_range(0, 99);
            op = (r < 45) ? ffpa_pkg::OP_ALLOC : (r < 80) ? ffpa_pkg::OP_FREE :
                 (r < 90) ? ffpa_pkg::OP_MAX : ffpa_pkg::OP_SCOPE;
            if (op == ffpa_pkg::OP_FREE)
                a = pick_free_address();
            else if ($urandom_range(0, 1))
                a = shadow_base + $urandom_range(0, 1 << 16) - 8;
            else
                a = $urandom();
            issue(op, pick_size(), a, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
            items++;
        end

        drain_results();
        idle_cycles(300);
        $display("covered %0d results, %0d granted allocations, %0d granted frees",
                 results_seen, allocs_granted, frees_granted);
        $display("over directed extremes, a full table, shrunk regions and random traffic");
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
